/* src/fpsm_pkg.sv */
package fpsm_pkg;

    // Field and register widths
    localparam int THRESH_W = 10;
    localparam int MODE_W   = 2;
    localparam int TIME_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int SPEED_W  = 48;
    localparam int CFG_W    = THRESH_W;
    localparam int IDX_W    = 1;

    // Speed constants: pi in millionths, degrees per half turn
    localparam longint unsigned PI_MICRO   = 64'd3141592;
    localparam longint unsigned DEG_HALF   = 64'd180;
    localparam longint unsigned DEG_HALF_K = 64'd180000;
    localparam longint unsigned DEN_MICRO  = 64'd1000000;
    localparam longint unsigned DEN_MILLI  = 64'd1000;

    // Divider widths
    localparam int NUM_W = $clog2(PI_MICRO + 64'd1) + FRAC_W;
    localparam int DEN_W = $clog2(DEN_MICRO + 64'd1);
    localparam int DVS_W = TIME_W + DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(560);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [IDX_W-1:0] REG_UNIT_MODE = 1'd1;

    // Unit mode codes
    localparam logic [MODE_W-1:0] MODE_RAD_MS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAD_S  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEG_MS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DEG_S  = 2'd3;

    // Scaled numerator N * 2^FRAC_W for the selected unit
    function automatic logic [NUM_W-1:0] speed_num(input logic [MODE_W-1:0] mode);
        logic [NUM_W-1:0] n;
        case (mode)
            MODE_RAD_MS: n = NUM_W'(PI_MICRO << FRAC_W);
            MODE_RAD_S:  n = NUM_W'(PI_MICRO << FRAC_W);
            MODE_DEG_MS: n = NUM_W'(DEG_HALF << FRAC_W);
            MODE_DEG_S:  n = NUM_W'(DEG_HALF_K << FRAC_W);
            default:     n = NUM_W'(DEG_HALF_K << FRAC_W);
        endcase
        return n;
    endfunction

    // Denominator D for the selected unit
    function automatic logic [DEN_W-1:0] speed_den(input logic [MODE_W-1:0] mode);
        logic [DEN_W-1:0] d;
        case (mode)
            MODE_RAD_MS: d = DEN_W'(DEN_MICRO);
            MODE_RAD_S:  d = DEN_W'(DEN_MILLI);
            MODE_DEG_MS: d = DEN_W'(1);
            MODE_DEG_S:  d = DEN_W'(1);
            default:     d = DEN_W'(1);
        endcase
        return d;
    endfunction

endpackage

/* src/flywheel_period_speed_meter_core.sv */
// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_ready   sample, now_ms
// out       output     out_valid / out_ready edge_seen, half_period, full_period, speed
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// A beat with an edge passes accept, the divisor product register (S_MUL), the
// bit-serial restoring divider over the NUM_W (38)-bit numerator (S_DIV) and the
// result load; a beat with no edge (or a zero half period) goes straight to the load.
// One beat is in work at a time; the next is taken while a result waits at the output.
// rst_n clears all state; threshold resets to 560 and unit mode to rad/ms.
// A stalled output holds the finished result and blocks only the next load.
module flywheel_period_speed_meter_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fpsm_pkg::IDX_W-1:0]         cfg_index,
    input  logic [fpsm_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fpsm_pkg::THRESH_W-1:0]      sample,
    input  logic [fpsm_pkg::TIME_W-1:0]        now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               edge_seen,
    output logic [fpsm_pkg::TIME_W-1:0]        half_period,
    output logic [fpsm_pkg::TIME_W-1:0]        full_period,
    output logic [fpsm_pkg::SPEED_W-1:0]       speed
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

    state_t                             state_reg;
    logic [fpsm_pkg::THRESH_W-1:0]      threshold_reg;
    logic [fpsm_pkg::MODE_W-1:0]        unit_mode_reg;
    logic                               was_above_reg;
    logic [fpsm_pkg::TIME_W-1:0]        last_edge_reg;
    logic [fpsm_pkg::TIME_W-1:0]        slot_a_reg;
    logic [fpsm_pkg::TIME_W-1:0]        slot_b_reg;
    logic                               slot_toggle_reg;
    logic                               res_edge_reg;
    logic [fpsm_pkg::TIME_W-1:0]        half_reg;
    logic [fpsm_pkg::TIME_W-1:0]        full_reg;
    logic [fpsm_pkg::DVS_W-1:0]         dvs_reg;
    logic [fpsm_pkg::DVS_W-1:0]         rem_reg;
    logic [fpsm_pkg::NUM_W-1:0]         quo_reg;
    logic [fpsm_pkg::CNT_W-1:0]         cnt_reg;
    logic                               out_valid_reg;
    logic                               edge_seen_reg;
    logic [fpsm_pkg::TIME_W-1:0]        half_period_reg;
    logic [fpsm_pkg::TIME_W-1:0]        full_period_reg;
    logic [fpsm_pkg::SPEED_W-1:0]       speed_reg;

    logic                               in_fire;
    logic                               above;
    logic                               edge_hit;
    logic [fpsm_pkg::TIME_W-1:0]        half_now;
    logic [fpsm_pkg::DVS_W-1:0]         prod;
    logic [fpsm_pkg::DVS_W:0]           rem_sh;
    logic [fpsm_pkg::DVS_W+1:0]         diff;
    logic [fpsm_pkg::DVS_W-1:0]         rem_next;
    logic [fpsm_pkg::NUM_W-1:0]         quo_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign edge_seen   = edge_seen_reg;
    assign half_period = half_period_reg;
    assign full_period = full_period_reg;
    assign speed       = speed_reg;

    // Edge detect and half period
    assign above    = (sample > threshold_reg);
    assign edge_hit = above && !was_above_reg;
    assign half_now = now_ms - last_edge_reg;

    // Divisor T * D, registered before the divider starts
    assign prod = fpsm_pkg::DVS_W'(half_reg)
                * fpsm_pkg::DVS_W'(fpsm_pkg::speed_den(unit_mode_reg));

    // One restoring step: shift in a dividend bit, trial subtract
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[fpsm_pkg::NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        if (!diff[fpsm_pkg::DVS_W+1])
        begin
            rem_next = diff[fpsm_pkg::DVS_W-1:0];
            quo_next = {quo_reg[fpsm_pkg::NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[fpsm_pkg::DVS_W-1:0];
            quo_next = {quo_reg[fpsm_pkg::NUM_W-2:0], 1'b0};
        end
    end

    // Control, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            threshold_reg   <= fpsm_pkg::THRESH_RESET;
            unit_mode_reg   <= fpsm_pkg::MODE_RAD_MS;
            was_above_reg   <= 1'b0;
            last_edge_reg   <= '0;
            slot_a_reg      <= '0;
            slot_b_reg      <= '0;
            slot_toggle_reg <= 1'b0;
            res_edge_reg    <= 1'b0;
            half_reg        <= '0;
            full_reg        <= '0;
            dvs_reg         <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            edge_seen_reg   <= 1'b0;
            half_period_reg <= '0;
            full_period_reg <= '0;
            speed_reg       <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    fpsm_pkg::REG_THRESHOLD:
                        threshold_reg <= cfg_data[fpsm_pkg::THRESH_W-1:0];
                    fpsm_pkg::REG_UNIT_MODE:
                        unit_mode_reg <= cfg_data[fpsm_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end

            // output beat taken; in S_DONE the reload handles that cycle
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        was_above_reg <= above;
                        res_edge_reg  <= 1'b0;
                        half_reg      <= half_now;
                        state_reg     <= S_DONE;
                        if (edge_hit)
                        begin
                            last_edge_reg   <= now_ms;
                            slot_toggle_reg <= !slot_toggle_reg;
                            if (!slot_toggle_reg)
                            begin
                                slot_a_reg <= half_now;
                            end
                            else
                            begin
                                slot_b_reg <= half_now;
                            end
                            if (half_now != '0)
                            begin
                                res_edge_reg <= 1'b1;
                                state_reg    <= S_MUL;
                            end
                        end
                    end
                end

                S_MUL:
                begin
                    full_reg  <= slot_a_reg + slot_b_reg;
                    dvs_reg   <= prod;
                    quo_reg   <= fpsm_pkg::speed_num(unit_mode_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= fpsm_pkg::CNT_W'(fpsm_pkg::NUM_W);
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - fpsm_pkg::CNT_W'(1);
                    if (cnt_reg == fpsm_pkg::CNT_W'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // load when the output register is free or being emptied
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        edge_seen_reg <= res_edge_reg;
                        if (res_edge_reg)
                        begin
                            half_period_reg <= half_reg;
                            full_period_reg <= full_reg;
                            speed_reg       <= fpsm_pkg::SPEED_W'(quo_reg);
                        end
                        else
                        begin
                            half_period_reg <= '0;
                            full_period_reg <= '0;
                            speed_reg       <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_edge_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_seen |-> half_period != '0)
        else $error("edge result with zero half period");

    a_noedge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_seen |-> half_period == '0 && full_period == '0 && speed == '0)
        else $error("non-edge result carries data");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fpsm_pkg::CNT_W'(fpsm_pkg::NUM_W))
        else $error("divider count out of range");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while one is in work");

    a_speed_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed[fpsm_pkg::SPEED_W-1:fpsm_pkg::NUM_W] == '0)
        else $error("speed exceeds quotient width");

endmodule

/* tb/sv/flywheel_period_speed_meter_core_tb.sv */
module flywheel_period_speed_meter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_ROWS     = 30;
    localparam int NUM_PHASES   = 9;
    localparam longint unsigned SPEED_CAP = (64'd1 << fpsm_pkg::SPEED_W) - 64'd1;

    typedef struct packed {
        logic                              edge_seen;
        logic [fpsm_pkg::TIME_W-1:0]       half_period;
        logic [fpsm_pkg::TIME_W-1:0]       full_period;
        logic [fpsm_pkg::SPEED_W-1:0]      speed;
    } meter_result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [fpsm_pkg::IDX_W-1:0]        idx;
        logic [fpsm_pkg::THRESH_W-1:0]     smp;
        logic [fpsm_pkg::TIME_W-1:0]       tval;
        logic                              typed_in;
        meter_result_t                     want;
    } stim_row_t;

    typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE } rx_style_t;

    localparam meter_result_t NO_RESULT = '0;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [fpsm_pkg::IDX_W-1:0]         cfg_index;
    logic [fpsm_pkg::CFG_W-1:0]         cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic [fpsm_pkg::THRESH_W-1:0]      sample;
    logic [fpsm_pkg::TIME_W-1:0]        now_ms;
    logic                               out_valid;
    logic                               out_ready;
    logic                               edge_seen;
    logic [fpsm_pkg::TIME_W-1:0]        half_period;
    logic [fpsm_pkg::TIME_W-1:0]        full_period;
    logic [fpsm_pkg::SPEED_W-1:0]       speed;

    flywheel_period_speed_meter_core dut (.*);

    // Shadow of the block's registers and tacho state
    logic [fpsm_pkg::THRESH_W-1:0]      thr_shadow  = fpsm_pkg::THRESH_RESET;
    logic [fpsm_pkg::MODE_W-1:0]        mode_shadow = fpsm_pkg::MODE_RAD_MS;
    logic                               above_prev  = 1'b0;
    logic [fpsm_pkg::TIME_W-1:0]        edge_stamp  = '0;
    logic [fpsm_pkg::TIME_W-1:0]        half_even   = '0;
    logic [fpsm_pkg::TIME_W-1:0]        half_odd    = '0;
    logic                               fill_odd    = 1'b0;

    meter_result_t                      readings_due[$];
    stim_row_t                          plan [NUM_ROWS];
    int                                 fail_count = 0;
    int                                 beat_no    = 0;
    bit                                 gaps_on    = 1'b1;
    int                                 burst_left = 0;
    bit                                 hold_pending = 1'b0;
    logic [fpsm_pkg::TIME_W-1:0]        stamp_ms   = '0;
    bit                                 want_high  = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Angular rate in Q32.16 for the current unit, truncated
    function automatic logic [fpsm_pkg::SPEED_W-1:0] rate_for(
        input logic [fpsm_pkg::TIME_W-1:0] half);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        case (mode_shadow)
            fpsm_pkg::MODE_RAD_MS:
            begin
                n = fpsm_pkg::PI_MICRO;
                d = fpsm_pkg::DEN_MICRO;
            end
            fpsm_pkg::MODE_RAD_S:
            begin
                n = fpsm_pkg::PI_MICRO;
                d = fpsm_pkg::DEN_MILLI;
            end
            fpsm_pkg::MODE_DEG_MS:
            begin
                n = fpsm_pkg::DEG_HALF;
                d = 64'd1;
            end
            default:
            begin
                n = fpsm_pkg::DEG_HALF_K;
                d = 64'd1;
            end
        endcase
        q = ((n << fpsm_pkg::FRAC_W) / {32'd0, half}) / d;
        if (q > SPEED_CAP)
            q = SPEED_CAP;
        return q[fpsm_pkg::SPEED_W-1:0];
    endfunction

    // Advance the shadow state by one accepted sample
    function automatic meter_result_t meter_step(input logic [fpsm_pkg::THRESH_W-1:0] s,
                                                 input logic [fpsm_pkg::TIME_W-1:0] t);
        meter_result_t r;
        logic above;
        logic rising;
        logic [fpsm_pkg::TIME_W-1:0] half;
        r = '0;
        above = (s > thr_shadow);
        rising = above && !above_prev;
        above_prev = above;
        if (rising)
        begin
            half = t - edge_stamp;
            edge_stamp = t;
            if (!fill_odd)
                half_even = half;
            else
                half_odd = half;
            fill_odd = !fill_odd;
            // a zero half period still moves the state but reports nothing
            if (half != '0)
            begin
                r.edge_seen   = 1'b1;
                r.half_period = half;
                r.full_period = half_even + half_odd;
                r.speed       = rate_for(half);
            end
        end
        return r;
    endfunction

    // Offer one beat, hold it until taken, then maybe open a gap
    task automatic send_beat(input logic [fpsm_pkg::THRESH_W-1:0] s,
                             input logic [fpsm_pkg::TIME_W-1:0] t,
                             input logic use_fixed, input meter_result_t fixed_res);
        meter_result_t r;
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        now_ms   <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = meter_step(s, t);
        readings_due.push_back(use_fixed ? fixed_res : r);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
                burst_left--;
        end
    endtask

    // Register write, only while the block is idle
    task automatic write_reg(input logic [fpsm_pkg::IDX_W-1:0] idx,
                             input logic [fpsm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == fpsm_pkg::REG_THRESHOLD)
            thr_shadow = val[fpsm_pkg::THRESH_W-1:0];
        else if (idx == fpsm_pkg::REG_UNIT_MODE)
            mode_shadow = val[fpsm_pkg::MODE_W-1:0];
    endtask

    // Stop offering and wait for every outstanding reading
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly crossings around the threshold, time moving forward with odd jumps
    task automatic next_random(output logic [fpsm_pkg::THRESH_W-1:0] s,
                               output logic [fpsm_pkg::TIME_W-1:0] t);
        int pick;
        int step_pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            want_high = !want_high;
        if (pick >= 90)
            s = fpsm_pkg::THRESH_W'($urandom);
        else if (want_high && thr_shadow != {fpsm_pkg::THRESH_W{1'b1}})
            s = fpsm_pkg::THRESH_W'($urandom_range(1023, int'(thr_shadow) + 1));
        else if (!want_high)
            s = fpsm_pkg::THRESH_W'($urandom_range(int'(thr_shadow), 0));
        else
            s = fpsm_pkg::THRESH_W'($urandom);
        step_pick = $urandom_range(0, 99);
        if (step_pick < 15)
            stamp_ms = stamp_ms;
        else if (step_pick < 75)
            stamp_ms = stamp_ms + fpsm_pkg::TIME_W'($urandom_range(1, 50));
        else if (step_pick < 90)
            stamp_ms = stamp_ms + fpsm_pkg::TIME_W'($urandom_range(51, 100000));
        else
            stamp_ms = fpsm_pkg::TIME_W'($urandom);
        t = stamp_ms;
    endtask

    // Receiver: its own stall pattern, plus one long hold-off on request
    initial
    begin
        int span;
        rx_style_t style;
        span = 0;
        style = RX_OPEN;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    span  = $urandom_range(10, 80);
                end
                span--;
                case (style)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
                    default:   out_ready <= (span % 3 == 0);
                endcase
            end
        end
    end

    // Result checker
    initial
    begin
        meter_result_t got;
        meter_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{edge_seen, half_period, full_period, speed};
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"beat %0d: result with none pending: ",
                                  "edge=%0d half=%0d full=%0d speed=%0d"},
                                 beat_no, got.edge_seen, got.half_period,
                                 got.full_period, got.speed);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.edge_seen !== want.edge_seen ||
                        got.half_period !== want.half_period ||
                        got.full_period !== want.full_period ||
                        got.speed !== want.speed)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("beat %0d: expected edge=%0d half=%0d full=%0d speed=%0d",
                                     beat_no, want.edge_seen, want.half_period,
                                     want.full_period, want.speed);
                            $display("beat %0d: actual   edge=%0d half=%0d full=%0d speed=%0d",
                                     beat_no, got.edge_seen, got.half_period,
                                     got.full_period, got.speed);
                        end
                    end
                end
                beat_no++;
            end
        end
    end

    // Watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [fpsm_pkg::THRESH_W-1:0] s;
        logic [fpsm_pkg::TIME_W-1:0]   t;
        logic [fpsm_pkg::THRESH_W-1:0] thr;
        logic [fpsm_pkg::MODE_W-1:0]   mode;
        int n;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        now_ms    = '0;

        // Directed rows: edges, levels at the threshold, zero half period, wrap
        plan = '{
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd5,         1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd561,  32'd100,       1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd150,       1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd560,  32'd200,       1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd561,  32'd300,       1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd300,       1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd300,       1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd301,       1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd302,       1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'hFFFF_FFFF, 1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd5,         1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd5,         1'b0, NO_RESULT},
            '{ROW_CFG,  fpsm_pkg::REG_UNIT_MODE, 10'd0,    32'(fpsm_pkg::MODE_DEG_S),
              1'b0, NO_RESULT},
            '{ROW_CFG,  fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd0,         1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd5,         1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1,    32'd6,         1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd6,         1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1,    32'd5,         1'b0, NO_RESULT},
            '{ROW_CFG,  fpsm_pkg::REG_UNIT_MODE, 10'd0,    32'(fpsm_pkg::MODE_DEG_MS),
              1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd7,         1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd512,  32'd100,       1'b0, NO_RESULT},
            '{ROW_CFG,  fpsm_pkg::REG_UNIT_MODE, 10'd0,    32'(fpsm_pkg::MODE_RAD_S),
              1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd120,       1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd4000,      1'b0, NO_RESULT},
            '{ROW_CFG,  fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd1023,      1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd4100,      1'b1, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd4200,      1'b1, NO_RESULT},
            '{ROW_CFG,  fpsm_pkg::REG_THRESHOLD, 10'd0,    32'd1022,      1'b0, NO_RESULT},
            '{ROW_ITEM, fpsm_pkg::REG_THRESHOLD, 10'd1023, 32'd4300,      1'b0, NO_RESULT}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].tval[fpsm_pkg::CFG_W-1:0]);
            end
            else
                send_beat(plan[i].smp, plan[i].tval, plan[i].typed_in, plan[i].want);
        end

        // Random phases: extremes of threshold and every unit first, then mixed
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    thr  = fpsm_pkg::THRESH_W'(560);
                    mode = fpsm_pkg::MODE_RAD_MS;
                end
                1:
                begin
                    thr  = '0;
                    mode = fpsm_pkg::MODE_RAD_S;
                end
                2:
                begin
                    thr  = '1;
                    mode = fpsm_pkg::MODE_DEG_MS;
                end
                3:
                begin
                    thr  = fpsm_pkg::THRESH_W'(1);
                    mode = fpsm_pkg::MODE_DEG_S;
                end
                default:
                begin
                    thr  = fpsm_pkg::THRESH_W'($urandom);
                    mode = fpsm_pkg::MODE_W'($urandom);
                end
            endcase
            write_reg(fpsm_pkg::REG_THRESHOLD, fpsm_pkg::CFG_W'(thr));
            write_reg(fpsm_pkg::REG_UNIT_MODE, fpsm_pkg::CFG_W'(mode));
            // back-to-back beats against a long output stall in one phase
            gaps_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 1)
                hold_pending = 1'b1;
            n = (p == 2) ? 30 : 65;
            repeat (n)
            begin
                next_random(s, t);
                send_beat(s, t, 1'b0, NO_RESULT);
            end
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
